// ===== hdl/slir_pkg.sv =====
// Shared types and constants for the sorted list insert/remove block.
package slir_pkg;

  // Default number of stored values
  localparam int SLIR_CAPACITY = 16;

  // Field widths of the channel payloads
  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int OCC_W   = 5;

  // Operation codes of an input item
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_LIST   = 2'd3
  } kind_t;

  // Status codes of a result item
  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FULL     = 3'd1,
    STAT_NOTFOUND = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_ELEM     = 3'd4
  } status_t;

  // Input item
  typedef struct packed {
    kind_t                      kind;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  // Result item
  typedef struct packed {
    status_t                    status;
    logic signed [VALUE_W-1:0]  item;
    logic [OCC_W-1:0]           occupancy;
    logic                       last;
  } out_item_t;

  // Action that every cell of the chain applies together
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_ROTATE = 2'd3
  } chain_op_t;

  // Command from the controller to the chain
  typedef struct packed {
    chain_op_t                  op;
    logic signed [VALUE_W-1:0]  key;
  } chain_ctl_t;

endpackage

// ===== hdl/slir_cell.sv =====
// One storage cell of the sorted chain: a value and its neighbor moves.
module slir_cell import slir_pkg::*; (
  input  logic                       clk,
  input  chain_ctl_t                 ctl,
  input  logic                       beyond,     // cell index >= fill count
  input  logic                       tail,       // cell index == fill count - 1
  input  logic                       left_g,
  input  logic signed [VALUE_W-1:0]  left_val,
  input  logic signed [VALUE_W-1:0]  right_val,
  input  logic signed [VALUE_W-1:0]  head_val,
  output logic signed [VALUE_W-1:0]  val,
  output logic                       g,
  output logic                       eq
);

  logic signed [VALUE_W-1:0] val_r;
  logic signed [VALUE_W-1:0] val_nxt;

  // Flag cells at or past the key's place; monotone along the chain
  assign g   = beyond || (val_r >= ctl.key);
  assign eq  = !beyond && (val_r == ctl.key);
  assign val = val_r;

  // Pick the next value from neighbor, key or self
  always_comb begin
    val_nxt = val_r;
    unique case (ctl.op)
      OP_INSERT: begin
        if (left_g) begin
          val_nxt = left_val;
        end else if (g) begin
          val_nxt = ctl.key;
        end
      end
      OP_REMOVE: begin
        if (g) begin
          val_nxt = right_val;
        end
      end
      OP_ROTATE: begin
        val_nxt = tail ? head_val : right_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== hdl/slir_chain.sv =====
// Row of storage cells with per-cell range flags and match detection.
module slir_chain import slir_pkg::*; #(
  parameter int CAPACITY = SLIR_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                       clk,
  input  chain_ctl_t                 ctl,
  input  logic [CNT_W-1:0]           cnt,
  output logic signed [VALUE_W-1:0]  head,
  output logic                       found
);

  logic signed [VALUE_W-1:0] vals [CAPACITY];
  logic [CAPACITY-1:0]       gs;
  logic [CAPACITY-1:0]       eqs;

  genvar i;
  generate
    for (i = 0; i < CAPACITY; i++) begin : g_cell
      logic                      beyond;
      logic                      tail;
      logic                      left_g;
      logic signed [VALUE_W-1:0] left_val;
      logic signed [VALUE_W-1:0] right_val;

      assign beyond = (CNT_W'(i) >= cnt);
      assign tail   = (CNT_W'(i + 1) == cnt);

      // Tie off the ends of the chain
      if (i == 0) begin : g_first
        assign left_g   = 1'b0;
        assign left_val = ctl.key;
      end else begin : g_mid_l
        assign left_g   = gs[i-1];
        assign left_val = vals[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_val = vals[i];
      end else begin : g_mid_r
        assign right_val = vals[i+1];
      end

      slir_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .beyond    (beyond),
        .tail      (tail),
        .left_g    (left_g),
        .left_val  (left_val),
        .right_val (right_val),
        .head_val  (vals[0]),
        .val       (vals[i]),
        .g         (gs[i]),
        .eq        (eqs[i])
      );
    end
  endgenerate

  assign head  = vals[0];
  assign found = |eqs;

endmodule

// ===== hdl/sorted_list_insert_remove.sv =====
// Top level of the sorted list store: controller, output register and cell chain.
//
// Keeps up to CAPACITY signed 32-bit values in ascending order in a row of
// cells that compare against the key in parallel and shift by one place
// together. Insert, remove and clear pass through idle, which takes the item,
// and exec, which does the compare-and-shift across the chain and loads the
// result into the output register. List goes from idle and exec into the
// list state, which emits one stored value per cycle while the output
// register is free: the chain rotates left once per emitted value, so a list
// of N values returns the chain to its original order. An empty store lists
// as one result with status empty. A new item is taken while the last
// result still waits in the output register; results stall the chain only
// when that register is full.
module sorted_list_insert_remove import slir_pkg::*; #(
  parameter int CAPACITY = SLIR_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LIST = 3'b100
  } state_t;

  state_t                    state_r, state_nxt;
  kind_t                     kind_r, kind_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          rem_r, rem_nxt;
  logic                      out_valid_r, out_valid_nxt;
  out_item_t                 out_r, out_nxt;

  chain_ctl_t                ctl;
  logic signed [VALUE_W-1:0] head;
  logic                      found;
  logic                      out_free;
  logic                      full;

  assign out_free  = !out_valid_r || out_ready;
  assign full      = (cnt_r == CNT_W'(CAPACITY));
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  slir_chain #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .cnt   (cnt_r),
    .head  (head),
    .found (found)
  );

  // Sequence one item and drive the chain
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    ctl.op        = OP_HOLD;
    ctl.key       = key_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          key_nxt   = in_data.value;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_nxt.item  = '0;
          out_nxt.last  = 1'b1;
          out_nxt.status = STAT_OK;
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          unique case (kind_r)
            KIND_INSERT: begin
              if (full) begin
                out_nxt.status = STAT_FULL;
              end else begin
                ctl.op  = OP_INSERT;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            KIND_REMOVE: begin
              if (found) begin
                ctl.op  = OP_REMOVE;
                cnt_nxt = cnt_r - 1'b1;
              end else begin
                out_nxt.status = STAT_NOTFOUND;
              end
            end
            KIND_CLEAR: begin
              cnt_nxt = '0;
            end
            KIND_LIST: begin
              if (cnt_r == '0) begin
                out_nxt.status = STAT_EMPTY;
              end else begin
                // Hand over to the streaming state; no result yet
                out_valid_nxt = 1'b0;
                rem_nxt       = cnt_r;
                state_nxt     = S_LIST;
              end
            end
            default: begin
              out_nxt.status = STAT_OK;
            end
          endcase
          out_nxt.occupancy = OCC_W'(cnt_nxt);
        end
      end
      S_LIST: begin
        // Emit the head and rotate the chain by one
        if (out_free) begin
          ctl.op            = OP_ROTATE;
          out_nxt.status    = STAT_ELEM;
          out_nxt.item      = head;
          out_nxt.occupancy = OCC_W'(cnt_r);
          out_nxt.last      = (rem_r == CNT_W'(1));
          out_valid_nxt     = 1'b1;
          rem_nxt           = rem_r - 1'b1;
          if (rem_r == CNT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    key_r  <= key_nxt;
    out_r  <= out_nxt;
  end

  // Fill count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  // Streaming always has values left to emit
  a_list_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) |-> (rem_r != '0) && (cnt_r != '0))
    else $error("list state with nothing left");

  // Insert into a full store is refused and leaves the count alone
  a_full_refuse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && out_free && (kind_r == KIND_INSERT) && full
    |=> (out_r.status == STAT_FULL) && $stable(cnt_r) && out_valid_r)
    else $error("insert into full store not refused");

  // A list ends with the last flag and drops back to idle
  a_list_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LIST) && out_free && (rem_r == CNT_W'(1))
    |=> out_r.last && (state_r == S_IDLE))
    else $error("list did not close with last flag");

endmodule
